@@ sv/ptg_pkg.sv @@
// Shared types, constants and helper functions for the proportional glyph trimmer.
// No dependencies.
package ptg_pkg;

    localparam int ROW_W        = 32;
    localparam int HALF_BITS    = 16;
    localparam int BLANK_W      = 5;
    localparam int TRIM_W       = 4;
    localparam int WIDTH_W      = 6;
    localparam int DEF_MAX_ROWS = 32;

    localparam logic [TRIM_W-1:0]  SPACE_TRIM = 4'd6;
    localparam logic [BLANK_W-1:0] BLANK_INIT = 5'd16;
    localparam logic [WIDTH_W-1:0] FULL_WIDTH = 6'd32;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } ptg_state_t;

    typedef struct packed {
        logic              go;
        logic [TRIM_W-1:0] tl;
        logic [TRIM_W-1:0] tr;
    } ptg_start_t;

    // blank columns from bit 31 downward, left half only
    function automatic logic [BLANK_W-1:0] leading_blank16(input logic [ROW_W-1:0] row);
        logic [BLANK_W-1:0] n;
        n = BLANK_INIT;
        for (int i = HALF_BITS - 1; i >= 0; i--) begin
            if (row[ROW_W-1-i]) begin
                n = BLANK_W'(i);
            end
        end
        return n;
    endfunction

    // blank columns from bit 0 upward, right half only
    function automatic logic [BLANK_W-1:0] trailing_blank16(input logic [ROW_W-1:0] row);
        logic [BLANK_W-1:0] n;
        n = BLANK_INIT;
        for (int i = HALF_BITS - 1; i >= 0; i--) begin
            if (row[i]) begin
                n = BLANK_W'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [TRIM_W-1:0] trim_of(input logic [BLANK_W-1:0] m);
        logic [BLANK_W-1:0] d;
        d = m - 5'd1;
        return (m == '0) ? '0 : d[TRIM_W-1:0];
    endfunction

endpackage

@@ sv/ptg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ptg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ptg_load.sv @@
// Row loader: writes rows to the store, tracks edge blank minima, derives trims.
// Depends on ptg_pkg.
module ptg_load
    import ptg_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = $clog2(MAX_ROWS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [ROW_W-1:0] row_bits,
    input  logic             is_space,
    input  logic             last_row,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [ROW_W-1:0] wr_data,
    output ptg_start_t       start,
    output logic [CW-1:0]    count
);

    logic [CW-1:0]      rows_loaded_reg, rows_loaded_next;
    logic [BLANK_W-1:0] min_lead_reg, min_lead_next;
    logic [BLANK_W-1:0] min_trail_reg, min_trail_next;
    logic               store;
    logic [BLANK_W-1:0] lb, tb;
    logic [CW-1:0]      count_new;
    logic [BLANK_W-1:0] lead_new, trail_new;

    assign store = accept && (rows_loaded_reg < CW'(MAX_ROWS));
    assign lb    = leading_blank16(row_bits);
    assign tb    = trailing_blank16(row_bits);

    assign count_new = rows_loaded_reg + CW'(store);
    assign lead_new  = (store && (lb < min_lead_reg)) ? lb : min_lead_reg;
    assign trail_new = (store && (tb < min_trail_reg)) ? tb : min_trail_reg;

    assign wr_en   = store;
    assign wr_addr = rows_loaded_reg[AW-1:0];
    assign wr_data = row_bits;

    always_comb begin
        start.go = accept && last_row;
        start.tl = is_space ? SPACE_TRIM : trim_of(lead_new);
        start.tr = is_space ? SPACE_TRIM : trim_of(trail_new);
        count    = count_new;
    end

    always_comb begin
        rows_loaded_next = count_new;
        min_lead_next    = lead_new;
        min_trail_next   = trail_new;
        if (accept && last_row) begin
            rows_loaded_next = '0;
            min_lead_next    = BLANK_INIT;
            min_trail_next   = BLANK_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_loaded_reg <= '0;
            min_lead_reg    <= BLANK_INIT;
            min_trail_reg   <= BLANK_INIT;
        end else begin
            rows_loaded_reg <= rows_loaded_next;
            min_lead_reg    <= min_lead_next;
            min_trail_reg   <= min_trail_next;
        end
    end

endmodule

@@ sv/ptg_emit.sv @@
// Emit sequencer: reads stored rows, trims and left-aligns them, output register plus skid.
// Depends on ptg_pkg.
module ptg_emit
    import ptg_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = $clog2(MAX_ROWS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptg_start_t         start,
    input  logic [CW-1:0]      count,
    output logic               busy,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [ROW_W-1:0]   rd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ROW_W-1:0]   m_row_mask,
    output logic [WIDTH_W-1:0] m_glyph_width,
    output logic [TRIM_W-1:0]  m_left_trim,
    output logic               m_final_row
);

    ptg_state_t state_reg, state_next;

    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      last_k_reg, last_k_next;
    logic [TRIM_W-1:0]  tl_reg, tl_next;
    logic [ROW_W-1:0]   keep_reg, keep_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               pend_reg, pend_next;
    logic               pend_final_reg, pend_final_next;

    logic               out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]   out_mask_reg, out_mask_next;
    logic [WIDTH_W-1:0] out_width_reg, out_width_next;
    logic [TRIM_W-1:0]  out_tl_reg, out_tl_next;
    logic               out_final_reg, out_final_next;

    logic               hold_valid_reg, hold_valid_next;
    logic [ROW_W-1:0]   hold_mask_reg, hold_mask_next;
    logic [WIDTH_W-1:0] hold_width_reg, hold_width_next;
    logic [TRIM_W-1:0]  hold_tl_reg, hold_tl_next;
    logic               hold_final_reg, hold_final_next;

    logic               pop, issue, last_issue;
    logic [1:0]         occ;
    logic [ROW_W-1:0]   new_mask;
    logic [CW-1:0]      count_m1;

    assign pop        = out_valid_reg && m_ready;
    assign occ        = 2'(out_valid_reg) + 2'(hold_valid_reg) + 2'(pend_reg) - 2'(pop);
    assign last_issue = issue && (k_reg == last_k_reg);
    assign new_mask   = (rd_data & keep_reg) << tl_reg;
    assign count_m1   = count - CW'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (start.go) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (last_issue) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        busy  = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                busy  = 1'b0;
                issue = 1'b0;
            end
            ST_EMIT: begin
                busy  = 1'b1;
                issue = (occ < 2'd2);
            end
            default: begin
                busy  = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    assign rd_en   = issue;
    assign rd_addr = k_reg;

    always_comb begin
        k_next          = k_reg;
        last_k_next     = last_k_reg;
        tl_next         = tl_reg;
        keep_next       = keep_reg;
        width_next      = width_reg;
        pend_next       = issue;
        pend_final_next = last_issue;
        if (start.go) begin
            k_next      = '0;
            last_k_next = count_m1[AW-1:0];
            tl_next     = start.tl;
            keep_next   = (32'hFFFF_FFFF >> start.tl) & (32'hFFFF_FFFF << start.tr);
            width_next  = FULL_WIDTH - WIDTH_W'(start.tl) - WIDTH_W'(start.tr);
        end else if (issue) begin
            k_next = k_reg + AW'(1);
        end
    end

    // output register with one-deep skid
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_mask_next   = out_mask_reg;
        out_width_next  = out_width_reg;
        out_tl_next     = out_tl_reg;
        out_final_next  = out_final_reg;
        hold_valid_next = hold_valid_reg;
        hold_mask_next  = hold_mask_reg;
        hold_width_next = hold_width_reg;
        hold_tl_next    = hold_tl_reg;
        hold_final_next = hold_final_reg;
        if (!out_valid_reg || pop) begin
            out_valid_next = hold_valid_reg || pend_reg;
            if (hold_valid_reg) begin
                out_mask_next  = hold_mask_reg;
                out_width_next = hold_width_reg;
                out_tl_next    = hold_tl_reg;
                out_final_next = hold_final_reg;
            end else begin
                out_mask_next  = new_mask;
                out_width_next = width_reg;
                out_tl_next    = tl_reg;
                out_final_next = pend_final_reg;
            end
        end
        if ((hold_valid_reg && pop) || (!hold_valid_reg && out_valid_reg && !pop)) begin
            hold_valid_next = pend_reg;
            hold_mask_next  = new_mask;
            hold_width_next = width_reg;
            hold_tl_next    = tl_reg;
            hold_final_next = pend_final_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        last_k_reg     <= last_k_next;
        tl_reg         <= tl_next;
        keep_reg       <= keep_next;
        width_reg      <= width_next;
        pend_final_reg <= pend_final_next;
        out_mask_reg   <= out_mask_next;
        out_width_reg  <= out_width_next;
        out_tl_reg     <= out_tl_next;
        out_final_reg  <= out_final_next;
        hold_mask_reg  <= hold_mask_next;
        hold_width_reg <= hold_width_next;
        hold_tl_reg    <= hold_tl_next;
        hold_final_reg <= hold_final_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_row_mask    = out_mask_reg;
    assign m_glyph_width = out_width_reg;
    assign m_left_trim   = out_tl_reg;
    assign m_final_row   = out_final_reg;

endmodule

@@ sv/proportional_glyph_trimmer.sv @@
// One row is accepted per cycle while loading. After the last row is taken, the
// sequencer enters its emit state, reads the stored rows through the registered read
// port of the row store and presents them through the output register, one row per
// cycle while m_ready is high. Input is held off while stored rows are being read out.
// Reset (aresetn low, synchronous) clears row count, trackers, sequencer and valid
// flags; the row store is not cleared. Depends on ptg_pkg, ptg_ram, ptg_load, ptg_emit.
module proportional_glyph_trimmer
    import ptg_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ROW_W-1:0]   s_row_bits,
    input  logic               s_is_space,
    input  logic               s_last_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ROW_W-1:0]   m_row_mask,
    output logic [WIDTH_W-1:0] m_glyph_width,
    output logic [TRIM_W-1:0]  m_left_trim,
    output logic               m_final_row
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    logic             accept;
    logic             busy;
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [ROW_W-1:0] wr_data, rd_data;
    ptg_start_t       start;
    logic [CW-1:0]    count;

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    ptg_load #(
        .MAX_ROWS(MAX_ROWS)
    ) u_load (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .row_bits (s_row_bits),
        .is_space (s_is_space),
        .last_row (s_last_row),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .start    (start),
        .count    (count)
    );

    ptg_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_ROWS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptg_emit #(
        .MAX_ROWS(MAX_ROWS)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .count         (count),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_mask    (m_row_mask),
        .m_glyph_width (m_glyph_width),
        .m_left_trim   (m_left_trim),
        .m_final_row   (m_final_row)
    );

endmodule

@@ sv/ptg_checker.sv @@
// Port-level assertions for the proportional glyph trimmer, bound to the top level.
// Depends on ptg_pkg and proportional_glyph_trimmer.
module ptg_checker
    import ptg_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last_row,
    input logic               m_valid,
    input logic               m_ready,
    input logic [ROW_W-1:0]   m_row_mask,
    input logic [WIDTH_W-1:0] m_glyph_width,
    input logic [TRIM_W-1:0]  m_left_trim,
    input logic               m_final_row
);

    // a stalled word holds its row mask and final-row flag
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_mask) && $stable(m_final_row))
        else $error("output word changed while stalled");

    // closing row of a glyph starts readout, input held off
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_row |=> !s_ready)
        else $error("input taken during readout");

    // trimmed columns are zero
    a_mask_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_row_mask & ~(32'hFFFF_FFFF << (FULL_WIDTH - m_glyph_width))) == '0)
        else $error("bits set beyond glyph width");

    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_glyph_width >= 6'd2 && m_glyph_width <= FULL_WIDTH
                    && (7'(m_glyph_width) + 7'(m_left_trim)) <= 7'd32)
        else $error("glyph width out of range");

endmodule

bind proportional_glyph_trimmer ptg_checker u_ptg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_row    (s_last_row),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_row_mask    (m_row_mask),
    .m_glyph_width (m_glyph_width),
    .m_left_trim   (m_left_trim),
    .m_final_row   (m_final_row)
);

@@ test/tb_proportional_glyph_trimmer.sv @@
// Self-checking testbench for proportional_glyph_trimmer: random row/result idling,
// an in-bench trim predictor and an in-order compare of every trimmed row.
// Depends on ptg_pkg and the trimmer RTL.
`timescale 1ns / 1ps

module tb_proportional_glyph_trimmer
    import ptg_pkg::*;
();

    localparam int ROWS_CAP       = DEF_MAX_ROWS;
    localparam int QUIET_LIMIT    = 1000;
    localparam int TAIL_CYCLES    = 16;
    localparam int RANDOM_ROWS    = 97;

    typedef struct {
        logic [ROW_W-1:0] bits;
        logic             space;
        logic             last;
        int               gap;
        bit               drain;
    } glyph_row_t;

    typedef struct {
        logic [ROW_W-1:0]   mask;
        logic [WIDTH_W-1:0] width;
        logic [TRIM_W-1:0]  ltrim;
        logic               fin;
    } trimmed_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ROW_W-1:0]   s_row_bits = '0;
    logic               s_is_space = 1'b0;
    logic               s_last_row = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ROW_W-1:0]   m_row_mask;
    logic [WIDTH_W-1:0] m_glyph_width;
    logic [TRIM_W-1:0]  m_left_trim;
    logic               m_final_row;

    glyph_row_t   glyph_row_feed[$];
    trimmed_row_t trimmed_rows_due[$];
    glyph_row_t   next_row;
    trimmed_row_t want_row;

    logic [ROW_W-1:0] held_rows[ROWS_CAP];
    int rows_held = 0;
    int min_lead = HALF_BITS;
    int min_trail = HALF_BITS;
    bit rows_dropped = 0;

    int  errors = 0;
    int  glyph_cnt = 0;
    int  space_cnt = 0;
    int  overflow_cnt = 0;
    int  rows_in = 0;
    int  rows_checked = 0;
    int  gap_cnt = 0;
    int  stall_cnt = 0;
    int  stall = 0;
    int  quiet = 0;
    bit  tx_calm = 0;
    bit  rx_calm = 0;

    proportional_glyph_trimmer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_row_bits    (s_row_bits),
        .s_is_space    (s_is_space),
        .s_last_row    (s_last_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_mask    (m_row_mask),
        .m_glyph_width (m_glyph_width),
        .m_left_trim   (m_left_trim),
        .m_final_row   (m_final_row)
    );

    always #2 aclk = ~aclk;

    function automatic int lead_gap(input logic [ROW_W-1:0] r);
        int n;
        n = 0;
        while (n < HALF_BITS && !r[ROW_W-1-n]) n++;
        return n;
    endfunction

    function automatic int trail_gap(input logic [ROW_W-1:0] r);
        int n;
        n = 0;
        while (n < HALF_BITS && !r[n]) n++;
        return n;
    endfunction

    // store the row, track the edges, and on the last row predict every trimmed row
    task automatic load_row(input logic [ROW_W-1:0] r, input logic sp, input logic lst);
        int tl;
        int tr;
        logic [ROW_W-1:0] keep;
        trimmed_row_t t;
        rows_in++;
        if (rows_held < ROWS_CAP) begin
            held_rows[rows_held] = r;
            rows_held++;
            if (lead_gap(r) < min_lead) min_lead = lead_gap(r);
            if (trail_gap(r) < min_trail) min_trail = trail_gap(r);
        end else begin
            rows_dropped = 1;
        end
        if (lst) begin
            if (sp) begin
                tl = int'(SPACE_TRIM);
                tr = int'(SPACE_TRIM);
            end else begin
                tl = (min_lead == 0) ? 0 : min_lead - 1;
                tr = (min_trail == 0) ? 0 : min_trail - 1;
            end
            keep = ({ROW_W{1'b1}} >> tl) & ({ROW_W{1'b1}} << tr);
            for (int k = 0; k < rows_held; k++) begin
                t.mask  = (held_rows[k] & keep) << tl;
                t.width = WIDTH_W'(ROW_W - tl - tr);
                t.ltrim = TRIM_W'(tl);
                t.fin   = (k == rows_held - 1);
                trimmed_rows_due.push_back(t);
            end
            glyph_cnt++;
            if (sp) space_cnt++;
            if (rows_dropped) overflow_cnt++;
            rows_held = 0;
            min_lead = HALF_BITS;
            min_trail = HALF_BITS;
            rows_dropped = 0;
        end
    endtask

    task automatic queue_row(input logic [ROW_W-1:0] r, input logic sp, input logic lst,
                             input bit drain);
        glyph_row_t g;
        if ($urandom_range(0, 11) == 0) tx_calm = !tx_calm;
        g.bits  = r;
        g.space = sp;
        g.last  = lst;
        g.gap   = tx_calm ? 0 : $urandom_range(0, 8);
        g.drain = drain;
        glyph_row_feed.push_back(g);
    endtask

    task automatic queue_glyph(input int rows, input bit drain);
        int lk;
        int rk;
        logic [ROW_W-1:0] r;
        lk = $urandom_range(0, 17);
        rk = $urandom_range(0, 17);
        for (int i = 0; i < rows; i++) begin
            case ($urandom_range(0, 9))
                0: r = $urandom;
                1: r = '0;
                2: r = '1;
                default: r = $urandom & ({ROW_W{1'b1}} >> (lk + $urandom_range(0, 2)))
                                      & ({ROW_W{1'b1}} << (rk + $urandom_range(0, 2)));
            endcase
            if (i == rows - 1)
                queue_row(r, $urandom_range(0, 3) == 0, 1'b1, 1'b0);
            else
                queue_row(r, $urandom_range(0, 1), 1'b0, drain && i == 0);
        end
    endtask

    task automatic check_field(input string fname, input logic [ROW_W-1:0] want,
                               input logic [ROW_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_ready)
                load_row(s_row_bits, s_is_space, s_last_row);
            if (!s_valid || s_ready) begin
                if (glyph_row_feed.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_cnt < glyph_row_feed[0].gap ||
                             (glyph_row_feed[0].drain && trimmed_rows_due.size() != 0)) begin
                    s_valid <= 1'b0;
                    gap_cnt <= gap_cnt + 1;
                end else begin
                    next_row = glyph_row_feed.pop_front();
                    s_valid    <= 1'b1;
                    s_row_bits <= next_row.bits;
                    s_is_space <= next_row.space;
                    s_last_row <= next_row.last;
                    gap_cnt    <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (trimmed_rows_due.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected word, expected none, got mask %h width %0d",
                             $time, m_row_mask, m_glyph_width);
                end else begin
                    want_row = trimmed_rows_due.pop_front();
                    check_field("row_mask", want_row.mask, m_row_mask);
                    check_field("glyph_width", ROW_W'(want_row.width), ROW_W'(m_glyph_width));
                    check_field("left_trim", ROW_W'(want_row.ltrim), ROW_W'(m_left_trim));
                    check_field("final_row", ROW_W'(want_row.fin), ROW_W'(m_final_row));
                end
                rows_checked++;
                if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
                stall = rx_calm ? 0 : $urandom_range(0, 8);
                m_ready   <= (stall == 0);
                stall_cnt <= stall;
            end else if (stall_cnt > 0) begin
                m_ready   <= (stall_cnt == 1);
                stall_cnt <= stall_cnt - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge aclk);
        $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_proportional_glyph_trimmer: FAIL");
        $finish;
    end

    initial begin
        int n;
        int glyph_idx;
        // directed: blank, full, edge-only, saturating edges, space handling
        queue_row(32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        queue_row(32'h0001_8000, 1'b0, 1'b1, 1'b0);
        queue_row(32'h8000_0000, 1'b0, 1'b0, 1'b0);
        queue_row(32'h0000_0001, 1'b0, 1'b1, 1'b0);
        queue_row(32'h2000_0004, 1'b0, 1'b1, 1'b0);
        queue_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_row(32'h0000_0000, 1'b1, 1'b0, 1'b0);
        queue_row(32'h0F0F_0F0F, 1'b1, 1'b1, 1'b0);
        queue_row(32'h0000_0000, 1'b1, 1'b0, 1'b0);
        queue_row(32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_row(32'h0000_FFFF, 1'b0, 1'b1, 1'b0);
        queue_row(32'hFFFF_0000, 1'b0, 1'b1, 1'b0);

        // random: one glyph past the store depth, one exactly full, then short glyphs
        n = 0;
        glyph_idx = 0;
        while (n < RANDOM_ROWS) begin
            int rows;
            if (glyph_idx == 0)
                rows = ROWS_CAP + $urandom_range(1, 3);
            else if (glyph_idx == 1)
                rows = ROWS_CAP;
            else
                rows = $urandom_range(1, 8);
            queue_glyph(rows, glyph_idx == 0 || $urandom_range(0, 7) == 0);
            n += rows;
            glyph_idx++;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (glyph_row_feed.size() != 0 || s_valid || trimmed_rows_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (trimmed_rows_due.size() != 0) begin
            errors++;
            $display("%0t ns: %0d trimmed rows expected, got none", $time,
                     trimmed_rows_due.size());
        end

        $display("Covered %0d glyphs (%0d space, %0d over store depth), %0d rows in,",
                 glyph_cnt, space_cnt, overflow_cnt, rows_in);
        $display("%0d trimmed words checked, %0d mismatches.", rows_checked, errors);
        if (errors == 0)
            $display("tb_proportional_glyph_trimmer: PASS");
        else
            $display("tb_proportional_glyph_trimmer: FAIL");
        $finish;
    end

endmodule
